@@ src/sfm_pkg.sv @@
// Shared types, constants and defaults of the site frequency mask block.
package sfm_pkg;

   localparam int POSITIONS_DEF  = 32768;
   localparam int COUNT_BITS_DEF = 20;

   localparam int KIND_W     = 2;
   localparam int POS_W      = 15;
   localparam int FREQ_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_FREQ  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SITE_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SITE_HIGH = 2'd2;

   localparam logic [FREQ_W-1:0] MIN_FREQ_RST  = 16'd0;
   localparam logic [POS_W-1:0]  SITE_LOW_RST  = 15'd265;
   localparam logic [POS_W-1:0]  SITE_HIGH_RST = 15'd29674;

   typedef enum logic [KIND_W-1:0] {
      KIND_SAMPLE,
      KIND_HIT,
      KIND_BATCH_END,
      KIND_QUERY
   } kind_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SWEEP,
      ST_FLUSH
   } state_type;

endpackage

@@ src/sfm_ram.sv @@
// Single-port-write, single-port-read synchronous memory with registered read data.
module sfm_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = sfm_pkg::POSITIONS_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/site_frequency_mask.sv @@
// Top level of the site frequency mask: per-batch site histogram and sticky mask.
//
// Samples and site hits are taken one per cycle while the block is idle; hits to
// the same position in consecutive cycles are forwarded around the registered
// read of the counter memory. A mask query is read from the mask memory and its
// result registered; a second query waits until the first has moved into the
// output register and that register can take another result. A batch end sweeps
// the counter memory one position per cycle and holds stall through the sweep
// and its flush state. After reset the block clears both memories, one position
// per cycle, and holds stall while clearing; configuration writes are taken
// throughout.
module site_frequency_mask #(
   parameter int POSITIONS  = sfm_pkg::POSITIONS_DEF,
   parameter int COUNT_BITS = sfm_pkg::COUNT_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [sfm_pkg::KIND_W-1:0]     req_kind,
   input  logic [sfm_pkg::POS_W-1:0]      req_position,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [sfm_pkg::POS_W-1:0]      rsp_queried_position,
   output logic                           rsp_keep,
   input  logic                           csr_write,
   input  logic [sfm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sfm_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int ADDR_W = $clog2(POSITIONS);
   localparam int NEED_W = sfm_pkg::FREQ_W + COUNT_BITS;
   localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(POSITIONS - 1);
   localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;

   sfm_pkg::state_type state_ff, state_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic sweep_issue, clear_wr;

   logic [sfm_pkg::FREQ_W-1:0] min_freq_ff;
   logic [sfm_pkg::POS_W-1:0]  site_low_ff, site_high_ff;

   logic [COUNT_BITS-1:0] sample_ff, sample_in;
   logic [NEED_W-1:0]     need_ff;

   logic              sweep_s1_ff;
   logic [ADDR_W-1:0] sweep_addr_s1_ff;
   logic              hit_s1_ff;
   logic [ADDR_W-1:0] hit_addr_s1_ff;
   logic              qry_s1_ff;
   logic              qry_in_s1_ff;
   logic [sfm_pkg::POS_W-1:0] qry_pos_s1_ff;

   logic                  fwd_valid_ff;
   logic [ADDR_W-1:0]     fwd_addr_ff;
   logic [COUNT_BITS-1:0] fwd_data_ff;

   logic                      rsp_valid_ff;
   logic [sfm_pkg::POS_W-1:0] rsp_pos_ff;
   logic                      rsp_keep_ff;

   logic                  accept, is_sample, is_hit, is_batch, is_query;
   logic [31:0]           pos_ext;
   logic                  in_store, in_window, hit_ok;
   logic [ADDR_W-1:0]     req_addr;
   logic                  cnt_rd_en, cnt_wr_en;
   logic [ADDR_W-1:0]     cnt_rd_addr, cnt_wr_addr;
   logic [COUNT_BITS-1:0] cnt_wr_data, cnt_rd_data, cnt_cur, cnt_inc;
   logic                  mask_rd_en, mask_wr_en;
   logic [ADDR_W-1:0]     mask_wr_addr;
   logic                  mask_wr_data, mask_rd_data;
   logic                  pass;

   assign is_sample = (req_kind == sfm_pkg::KIND_SAMPLE);
   assign is_hit    = (req_kind == sfm_pkg::KIND_HIT);
   assign is_batch  = (req_kind == sfm_pkg::KIND_BATCH_END);
   assign is_query  = (req_kind == sfm_pkg::KIND_QUERY);

   assign req_stall = (state_ff != sfm_pkg::ST_IDLE) ||
                      (is_query && (qry_s1_ff || (rsp_valid_ff && rsp_stall)));
   assign accept    = req_valid && !req_stall;

   assign pos_ext   = 32'(req_position);
   assign in_store  = pos_ext < 32'(POSITIONS);
   assign req_addr  = pos_ext[ADDR_W-1:0];
   assign in_window = (req_position >= site_low_ff) && (req_position <= site_high_ff);
   assign hit_ok    = accept && is_hit && in_window && in_store;

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      sweep_issue = 1'b0;
      clear_wr    = 1'b0;
      case (state_ff)
         sfm_pkg::ST_CLEAR: begin
            clear_wr = 1'b1;
            idx_in   = idx_ff + 1'b1;
            if (idx_ff == LAST_ADDR) begin
               idx_in   = '0;
               state_in = sfm_pkg::ST_IDLE;
            end
         end
         sfm_pkg::ST_IDLE: begin
            if (accept && is_batch) begin
               state_in = sfm_pkg::ST_SWEEP;
            end
         end
         sfm_pkg::ST_SWEEP: begin
            sweep_issue = 1'b1;
            idx_in      = idx_ff + 1'b1;
            if (idx_ff == LAST_ADDR) begin
               idx_in   = '0;
               state_in = sfm_pkg::ST_FLUSH;
            end
         end
         sfm_pkg::ST_FLUSH: begin
            state_in = sfm_pkg::ST_IDLE;
         end
         default: begin
            state_in = sfm_pkg::ST_CLEAR;
            idx_in   = '0;
         end
      endcase
   end

   // Counter update with forwarding of the previous cycle's write.
   assign cnt_cur = (fwd_valid_ff && (fwd_addr_ff == hit_addr_s1_ff)) ? fwd_data_ff
                                                                      : cnt_rd_data;
   assign cnt_inc = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + 1'b1;

   assign pass = (cnt_rd_data != '0) &&
                 ({cnt_rd_data, sfm_pkg::FREQ_W'(0)} >= need_ff);

   assign cnt_rd_en   = hit_ok || sweep_issue;
   assign cnt_rd_addr = sweep_issue ? idx_ff : req_addr;
   assign cnt_wr_en   = hit_s1_ff || sweep_s1_ff || clear_wr;
   assign cnt_wr_addr = clear_wr ? idx_ff : (sweep_s1_ff ? sweep_addr_s1_ff : hit_addr_s1_ff);
   assign cnt_wr_data = hit_s1_ff ? cnt_inc : '0;

   assign mask_rd_en   = accept && is_query && in_store;
   assign mask_wr_en   = clear_wr || (sweep_s1_ff && pass);
   assign mask_wr_addr = clear_wr ? idx_ff : sweep_addr_s1_ff;
   assign mask_wr_data = !clear_wr;

   sfm_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (POSITIONS)
   ) u_counts (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (cnt_rd_en),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   sfm_ram #(
      .WIDTH (1),
      .DEPTH (POSITIONS)
   ) u_mask (
      .clock   (clock),
      .wr_en   (mask_wr_en),
      .wr_addr (mask_wr_addr),
      .wr_data (mask_wr_data),
      .rd_en   (mask_rd_en),
      .rd_addr (req_addr),
      .rd_data (mask_rd_data)
   );

   always_comb begin
      sample_in = sample_ff;
      if (accept && is_sample && (sample_ff != CNT_MAX)) begin
         sample_in = sample_ff + 1'b1;
      end else if (accept && is_batch) begin
         sample_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sfm_pkg::ST_CLEAR;
         idx_ff       <= '0;
         min_freq_ff  <= sfm_pkg::MIN_FREQ_RST;
         site_low_ff  <= sfm_pkg::SITE_LOW_RST;
         site_high_ff <= sfm_pkg::SITE_HIGH_RST;
         sample_ff    <= '0;
         sweep_s1_ff  <= 1'b0;
         hit_s1_ff    <= 1'b0;
         qry_s1_ff    <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         sample_ff    <= sample_in;
         sweep_s1_ff  <= sweep_issue;
         hit_s1_ff    <= hit_ok;
         qry_s1_ff    <= accept && is_query;
         fwd_valid_ff <= hit_s1_ff;
         if (qry_s1_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            case (csr_index)
               sfm_pkg::CSR_MIN_FREQ:  min_freq_ff  <= csr_data;
               sfm_pkg::CSR_SITE_LOW:  site_low_ff  <= csr_data[sfm_pkg::POS_W-1:0];
               sfm_pkg::CSR_SITE_HIGH: site_high_ff <= csr_data[sfm_pkg::POS_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      sweep_addr_s1_ff <= idx_ff;
      hit_addr_s1_ff   <= req_addr;
      fwd_addr_ff      <= hit_addr_s1_ff;
      fwd_data_ff      <= cnt_inc;
      if (accept && is_batch) begin
         need_ff <= NEED_W'(min_freq_ff) * NEED_W'(sample_ff);
      end
      if (accept && is_query) begin
         qry_pos_s1_ff <= req_position;
         qry_in_s1_ff  <= in_store;
      end
      if (qry_s1_ff) begin
         rsp_pos_ff  <= qry_pos_s1_ff;
         rsp_keep_ff <= qry_in_s1_ff && mask_rd_data;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_queried_position = rsp_pos_ff;
   assign rsp_keep             = rsp_keep_ff;

endmodule

@@ src/sfm_checker.sv @@
// Port-level checks of the site frequency mask and their binding to the top level.
module sfm_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic [sfm_pkg::KIND_W-1:0] req_kind,
   input logic [sfm_pkg::POS_W-1:0]  req_position,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [sfm_pkg::POS_W-1:0]  rsp_queried_position,
   input logic                       rsp_keep
);

   logic req_take;
   logic query_take;
   logic batch_take;

   assign req_take   = req_valid && !req_stall;
   assign query_take = req_take && (req_kind == sfm_pkg::KIND_QUERY);
   assign batch_take = req_take && (req_kind == sfm_pkg::KIND_BATCH_END);

   // A result waiting on stall keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_queried_position) &&
                                 $stable(rsp_keep))
      else $error("stalled result transaction changed");

   // The memory clearing pass after reset takes no transactions.
   assert property (@(posedge clock) reset |=> req_stall)
      else $error("transaction accepted during the clearing pass");

   // A batch end starts the sweep, which takes no transactions.
   assert property (@(posedge clock) disable iff (reset)
      batch_take |=> req_stall)
      else $error("transaction accepted at the start of a sweep");

   // A new result appears only as the result of an accepted query.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(query_take, 2))
      else $error("result transaction without a query");

   // The position echoed in a result matches the query that caused it.
   assert property (@(posedge clock) disable iff (reset)
      query_take |=> ##1 (rsp_queried_position == $past(req_position, 2)))
      else $error("result position differs from the query");

endmodule

bind site_frequency_mask sfm_checker u_sfm_checker (.*);
